@@ rtl/pli_pkg.sv @@
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; every other file but pli_ram imports this package.
package pli_pkg;
   localparam int DataWidth  = 32;
   localparam int SegWidth   = 6;
   localparam int StatWidth  = 2;
   localparam int TolWidth   = 16;
   localparam int OpWidth    = 33;
   localparam int ProdWidth  = 2 * OpWidth;

   localparam logic [StatWidth-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatWidth-1:0] STATUS_RANGE = 2'd1;
   localparam logic [StatWidth-1:0] STATUS_FEW   = 2'd2;
   localparam logic [StatWidth-1:0] STATUS_FULL  = 2'd3;

   // Multiplier reciprocal of ten, exact for every 16-bit operand.
   localparam logic [TolWidth:0] RecipTen = 17'd52429;
   localparam int RecipShift = 19;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RDL, ST_RANGE, ST_GWAIT,
      ST_RA, ST_RB, ST_CHK, ST_MWAIT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MODE_GUESS, MODE_UP, MODE_DOWN
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_MUL, PH_DIV
   } phase_type;
endpackage

@@ rtl/pli_if.sv @@
// Handshake channel interfaces for request and response words.
// Depends on pli_pkg for field widths.
interface pli_req_if;
   import pli_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic signed [DataWidth-1:0] x_value;
   logic signed [DataWidth-1:0] y_value;
   logic                        first_point;
   modport source (output valid, req_type, x_value, y_value, first_point, input ready);
   modport sink   (input valid, req_type, x_value, y_value, first_point, output ready);
endinterface

interface pli_rsp_if;
   import pli_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] result_value;
   logic [SegWidth-1:0]         segment_index;
   logic [StatWidth-1:0]        status;
   modport source (output valid, result_value, segment_index, status, input ready);
   modport sink   (input valid, result_value, segment_index, status, output ready);
endinterface

@@ rtl/piecewise_linear_interpolator_unit.sv @@
// Top level of the piecewise linear interpolator: sequencer, point stores, result register.
// Depends on pli_pkg, pli_if, pli_ram and pli_muldiv.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    req_type, x_value, y_value, first_point
//   rsp       out   valid / ready    result_value, segment_index, status
//   csr       in    valid / ready    x_tolerance (16 bit), always ready
//
// A load is accepted and then handed to the response register. An evaluate reads the
// first and last points, checks the range, runs the shared multiply-divide unit for the
// segment guess when x lies at or above the first point and the last point lies above it,
// probes segments one at a time, runs the unit again for the interpolation and hands off.
// Reset is synchronous and empties the table. No word is taken while one is in work; a
// finished word waits in the sequencer only while the response register is still full.
module piecewise_linear_interpolator_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   pli_req_if.sink                         req_if,
   pli_rsp_if.source                       rsp_if,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pli_pkg::TolWidth-1:0]    csr_data
);
   import pli_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type                    state_ff, state_in;
   mode_type                     mode_ff, mode_in;
   logic [TolWidth-1:0]          tol_ff;
   logic [CW-1:0]                cnt_ff, cnt_in, cnt_eff;
   logic signed [DataWidth-1:0]  x_ff, x_in, x0_ff, x0_in, xa_ff, xa_in, ya_ff, ya_in;
   logic [AW-1:0]                ci_ff, ci_in, gi_ff, gi_in;
   logic                         dn_ff, dn_in, neg_ff, neg_in;
   logic signed [DataWidth-1:0]  res_ff, res_in;
   logic [SegWidth-1:0]          seg_ff, seg_in;
   logic [StatWidth-1:0]         sta_ff, sta_in;

   logic                         rsp_valid_ff, rsp_valid_in, hand_off;
   logic signed [DataWidth-1:0]  rsp_res_ff, rsp_res_in;
   logic [SegWidth-1:0]          rsp_seg_ff, rsp_seg_in;
   logic [StatWidth-1:0]         rsp_sta_ff, rsp_sta_in;

   logic                         accept, is_load, full, we;
   logic [AW-1:0]                raddr;
   logic signed [DataWidth-1:0]  x_rd, y_rd;

   logic                         u_start, u_done;
   logic [OpWidth-1:0]           u_a, u_b, u_d;
   logic [ProdWidth-1:0]         u_q;

   logic signed [33:0]           xs, x0s, xas, xbs, yas, ybs, tols, wid, w, absw;
   logic signed [33:0]           dy, dx, ysum, avg;
   logic [TolWidth+TolWidth:0]   widen_p;
   logic                         out_rng, guess_go, ins, up_f, dn_f, can_up, deg;
   logic [CW-1:0]                nm2;
   logic [AW-1:0]                g_clamp;
   logic [40:0]                  qs;
   logic signed [42:0]           rsum;
   logic signed [DataWidth-1:0]  rsat;

   assign accept  = req_if.valid && req_if.ready;
   assign is_load = !req_if.req_type;
   assign cnt_eff = req_if.first_point ? '0 : cnt_ff;
   assign full    = cnt_eff == CW'(TABLE_DEPTH);
   assign we      = accept && is_load && !full;

   pli_ram #(.WIDTH(DataWidth), .DEPTH(TABLE_DEPTH)) u_xram (
      .clock (clock), .we (we), .waddr (AW'(cnt_eff)), .wdata (req_if.x_value),
      .raddr (raddr), .rdata (x_rd)
   );
   pli_ram #(.WIDTH(DataWidth), .DEPTH(TABLE_DEPTH)) u_yram (
      .clock (clock), .we (we), .waddr (AW'(cnt_eff)), .wdata (req_if.y_value),
      .raddr (raddr), .rdata (y_rd)
   );

   pli_muldiv u_md (
      .clock (clock), .reset (reset), .start (u_start),
      .a (u_a), .b (u_b), .d (u_d), .done (u_done), .q (u_q)
   );

   // Working values in 34-bit signed form so no sum or difference can wrap.
   assign xs   = 34'(x_ff);
   assign x0s  = 34'(x0_ff);
   assign xas  = 34'(xa_ff);
   assign yas  = 34'(ya_ff);
   assign xbs  = 34'(x_rd);
   assign ybs  = 34'(y_rd);
   assign tols = 34'({18'd0, tol_ff});

   assign widen_p = tol_ff * RecipTen;
   assign wid     = 34'(widen_p >> RecipShift);
   assign out_rng = (xs < x0s - wid) || (xs > xbs + wid);
   assign guess_go = (xbs > x0s) && (xs >= x0s);

   assign nm2     = cnt_ff - CW'(2);
   assign g_clamp = (u_q > ProdWidth'(nm2)) ? AW'(nm2) : AW'(u_q);

   assign ins    = (xs >= xas - tols) && (xs <= xbs + tols);
   assign up_f   = xs > xbs;
   assign dn_f   = xs < xas;
   assign can_up = ((CW+1)'(ci_ff) + (CW+1)'(2)) < (CW+1)'(cnt_ff);
   assign w      = xbs - xas;
   assign absw   = w[33] ? -w : w;
   assign deg    = (w == '0) || (absw < tols);
   assign dy     = ybs - yas;
   assign dx     = xs - xas;
   assign ysum   = yas + ybs;
   assign avg    = (ysum + (ysum[33] ? 34'sd1 : 34'sd0)) >>> 1;

   // The interpolation quotient is held to 2^40, far past the result range.
   assign qs   = (u_q[ProdWidth-1:41] != '0 || (u_q[40] && u_q[39:0] != '0))
                 ? 41'h100_0000_0000 : u_q[40:0];
   assign rsum = neg_ff ? 43'(ya_ff) - 43'($signed({2'b0, qs}))
                        : 43'(ya_ff) + 43'($signed({2'b0, qs}));
   assign rsat = (rsum > 43'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (rsum < -43'sh0_8000_0000) ? 32'sh8000_0000 : DataWidth'(rsum);

   // A finished word moves to the response register once that register is free.
   assign hand_off     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);
   assign rsp_valid_in = hand_off || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_res_in   = hand_off ? res_ff : rsp_res_ff;
   assign rsp_seg_in   = hand_off ? seg_ff : rsp_seg_ff;
   assign rsp_sta_in   = hand_off ? sta_ff : rsp_sta_ff;

   // Shared unit operands: the segment guess in the range step, the slope term otherwise.
   always_comb begin
      if (state_ff == ST_RANGE) begin
         u_start = !out_rng && guess_go;
         u_a     = OpWidth'(cnt_ff - CW'(1));
         u_b     = OpWidth'(xs - x0s);
         u_d     = OpWidth'(xbs - x0s);
      end else begin
         u_start = (state_ff == ST_CHK) && (mode_ff == MODE_GUESS || ins) && ins && !deg;
         u_a     = OpWidth'(dy[33] ? -dy : dy);
         u_b     = OpWidth'(dx[33] ? -dx : dx);
         u_d     = OpWidth'(absw);
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_RDL:  raddr = AW'(cnt_ff - CW'(1));
         ST_RB:   raddr = ci_ff + AW'(1);
         ST_RA:   raddr = ci_ff;
         default: raddr = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_load || cnt_ff < CW'(2)) state_in = ST_OUT;
               else state_in = ST_RD0;
            end
         end
         ST_RD0:  state_in = ST_RDL;
         ST_RDL:  state_in = ST_RANGE;
         ST_RANGE: begin
            if (out_rng) state_in = ST_OUT;
            else if (guess_go) state_in = ST_GWAIT;
            else state_in = ST_RA;
         end
         ST_GWAIT: if (u_done) state_in = ST_RA;
         ST_RA:   state_in = ST_RB;
         ST_RB:   state_in = ST_CHK;
         ST_CHK: begin
            if (ins) state_in = deg ? ST_OUT : ST_MWAIT;
            else begin
               unique case (mode_ff)
                  MODE_GUESS: state_in = ((up_f && can_up) || (dn_f && ci_ff != '0))
                                         ? ST_RA : ST_OUT;
                  MODE_UP:    state_in = (can_up || (dn_ff && gi_ff != '0)) ? ST_RA : ST_OUT;
                  default:    state_in = (ci_ff != '0) ? ST_RA : ST_OUT;
               endcase
            end
         end
         ST_MWAIT: if (u_done) state_in = ST_OUT;
         ST_OUT:  if (hand_off) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      cnt_in = cnt_ff;
      mode_in = mode_ff;
      x_in = x_ff;
      x0_in = x0_ff;
      xa_in = xa_ff;
      ya_in = ya_ff;
      ci_in = ci_ff;
      gi_in = gi_ff;
      dn_in = dn_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      seg_in = seg_ff;
      sta_in = sta_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in   = req_if.x_value;
               res_in = '0;
               seg_in = '0;
               sta_in = STATUS_OK;
               if (is_load) begin
                  if (full) begin
                     sta_in = STATUS_FULL;
                     cnt_in = cnt_eff;
                  end else begin
                     cnt_in = cnt_eff + CW'(1);
                  end
               end else if (cnt_ff < CW'(2)) begin
                  sta_in = STATUS_FEW;
               end
            end
         end
         ST_RDL: x0_in = x_rd;
         ST_RANGE: begin
            mode_in = MODE_GUESS;
            ci_in   = '0;
            gi_in   = '0;
            if (out_rng) sta_in = STATUS_RANGE;
         end
         ST_GWAIT: begin
            if (u_done) begin
               ci_in = g_clamp;
               gi_in = g_clamp;
            end
         end
         ST_RB: begin
            xa_in = x_rd;
            ya_in = y_rd;
         end
         ST_CHK: begin
            if (ins) begin
               seg_in = SegWidth'(ci_ff);
               neg_in = dy[33] ^ dx[33] ^ w[33];
               if (deg) res_in = DataWidth'(avg);
            end else begin
               unique case (mode_ff)
                  MODE_GUESS: begin
                     dn_in = dn_f;
                     if (up_f && can_up) begin
                        mode_in = MODE_UP;
                        ci_in   = ci_ff + AW'(1);
                     end else if (dn_f && ci_ff != '0) begin
                        mode_in = MODE_DOWN;
                        ci_in   = ci_ff - AW'(1);
                     end else begin
                        sta_in = STATUS_RANGE;
                     end
                  end
                  MODE_UP: begin
                     if (can_up) begin
                        ci_in = ci_ff + AW'(1);
                     end else if (dn_ff && gi_ff != '0) begin
                        mode_in = MODE_DOWN;
                        ci_in   = gi_ff - AW'(1);
                     end else begin
                        sta_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     if (ci_ff != '0) ci_in = ci_ff - AW'(1);
                     else sta_in = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_MWAIT: if (u_done) res_in = rsat;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) tol_ff <= csr_data;
      end
      mode_ff    <= mode_in;
      x_ff       <= x_in;
      x0_ff      <= x0_in;
      xa_ff      <= xa_in;
      ya_ff      <= ya_in;
      ci_ff      <= ci_in;
      gi_ff      <= gi_in;
      dn_ff      <= dn_in;
      neg_ff     <= neg_in;
      res_ff     <= res_in;
      seg_ff     <= seg_in;
      sta_ff     <= sta_in;
      rsp_res_ff <= rsp_res_in;
      rsp_seg_ff <= rsp_seg_in;
      rsp_sta_ff <= rsp_sta_in;
   end

   assign csr_ready            = 1'b1;
   assign req_if.ready         = state_ff == ST_IDLE;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.result_value  = rsp_res_ff;
   assign rsp_if.segment_index = rsp_seg_ff;
   assign rsp_if.status        = rsp_sta_ff;
endmodule

@@ rtl/pli_ram.sv @@
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

@@ rtl/pli_muldiv.sv @@
// Shared iterative unit: shift-add multiply, then restoring divide, (a*b)/d.
// Depends on pli_pkg.
module pli_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [pli_pkg::OpWidth-1:0]   a,
   input  logic [pli_pkg::OpWidth-1:0]   b,
   input  logic [pli_pkg::OpWidth-1:0]   d,
   output logic                  done,
   output logic [pli_pkg::ProdWidth-1:0] q
);
   import pli_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic [ProdWidth-1:0]    acc_ff, acc_in, mc_ff, mc_in;
   logic [OpWidth-1:0]      mp_ff, mp_in, d_ff, d_in;
   logic [OpWidth:0]        rem_ff, rem_in, rem_sh;
   logic                    done_ff, done_in;

   assign rem_sh = {rem_ff[OpWidth-1:0], acc_ff[ProdWidth-1]};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mc_in    = mc_ff;
      mp_in    = mp_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               acc_in   = '0;
               mc_in    = ProdWidth'(a);
               mp_in    = b;
               d_in     = d;
               cnt_in   = 7'(OpWidth);
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            if (mp_ff[0]) begin
               acc_in = acc_ff + mc_ff;
            end
            mc_in  = {mc_ff[ProdWidth-2:0], 1'b0};
            mp_in  = {1'b0, mp_ff[OpWidth-1:1]};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               cnt_in   = 7'(ProdWidth);
               rem_in   = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            // One quotient bit per cycle enters at the bottom of the accumulator.
            if (rem_sh >= {1'b0, d_ff}) begin
               rem_in = rem_sh - {1'b0, d_ff};
               acc_in = {acc_ff[ProdWidth-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               acc_in = {acc_ff[ProdWidth-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign q    = acc_ff;
endmodule

@@ test/pli_tb_if.sv @@
`timescale 1ns / 1ps
// Testbench package: the response word type shared by the predictor and the checker.
// Depends on pli_pkg; the channel interfaces come from rtl/pli_if.sv.
package pli_tb_pkg;
   import pli_pkg::*;
   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic [SegWidth-1:0]         seg;
      logic [StatWidth-1:0]        status;
   } rsp_word_type;
endpackage

@@ test/piecewise_linear_interpolator_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise linear interpolator: loads tables, evaluates
// points and compares every response word with an in-bench predictor. Depends on
// pli_pkg, pli_if, pli_tb_pkg and the RTL.
module piecewise_linear_interpolator_unit_tb;
   import pli_pkg::*;
   import pli_tb_pkg::*;

   localparam int Depth = 64;
   localparam longint CycleLimit = 3000000;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [TolWidth-1:0] csr_data = '0;

   pli_req_if req_if ();
   pli_rsp_if rsp_if ();

   piecewise_linear_interpolator_unit #(.TABLE_DEPTH(Depth)) dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic signed [31:0] tab_x [Depth];
   logic signed [31:0] tab_y [Depth];
   int                 npts = 0;
   longint             tol = 0;

   rsp_word_type expected_words[$];
   int           errors = 0;
   longint       cycles = 0;

   task automatic report(string what, longint got, longint want);
      $display("error %0d: %s got %0d expected %0d", errors, what, got, want);
      errors++;
   endtask

   function automatic bit seg_holds(longint x, int i);
      return x >= longint'(tab_x[i]) - tol && x <= longint'(tab_x[i+1]) + tol;
   endfunction

   function automatic int locate_segment(longint x);
      longint x0, xl, g;
      x0 = tab_x[0];
      xl = tab_x[npts-1];
      g = 0;
      if (xl > x0) g = (longint'(npts - 1) * (x - x0)) / (xl - x0);
      if (g < 0) g = 0;
      if (g > npts - 2) g = npts - 2;
      if (seg_holds(x, int'(g))) return int'(g);
      if (x > tab_x[g+1])
         for (int i = int'(g) + 1; i + 1 < npts; i++) if (seg_holds(x, i)) return i;
      if (x < tab_x[g])
         for (int i = int'(g); i > 0; i--) if (seg_holds(x, i - 1)) return i - 1;
      return -1;
   endfunction

   // Works out the response word for one request word and updates the table.
   function automatic rsp_word_type interpolate_word(bit op, logic signed [31:0] xv,
                                                     logic signed [31:0] yv, bit first);
      rsp_word_type r;
      longint x, w, ya, yb, dy, dx, res;
      logic [127:0] num;
      logic [127:0] q;
      int s;
      r = '0;
      x = xv;
      if (!op) begin
         if (first) npts = 0;
         if (npts >= Depth) r.status = STATUS_FULL;
         else begin
            tab_x[npts] = xv;
            tab_y[npts] = yv;
            npts++;
         end
      end else if (npts < 2) begin
         r.status = STATUS_FEW;
      end else if (x < longint'(tab_x[0]) - tol / 10 ||
                   x > longint'(tab_x[npts-1]) + tol / 10) begin
         r.status = STATUS_RANGE;
      end else begin
         s = locate_segment(x);
         if (s < 0) r.status = STATUS_RANGE;
         else begin
            w = longint'(tab_x[s+1]) - tab_x[s];
            ya = tab_y[s];
            yb = tab_y[s+1];
            r.seg = s[5:0];
            if (w == 0 || (w < 0 ? -w : w) < tol) res = (ya + yb) / 2;
            else begin
               dy = yb - ya;
               dx = x - tab_x[s];
               num = 128'(dy < 0 ? -dy : dy) * 128'(dx < 0 ? -dx : dx);
               q = num / 128'(w < 0 ? -w : w);
               if (q > (128'd1 << 40)) q = 128'd1 << 40;
               res = (((dy < 0) != (dx < 0)) != (w < 0)) ? ya - longint'(q[63:0])
                                                         : ya + longint'(q[63:0]);
               if (res > 64'sd2147483647) res = 64'sd2147483647;
               if (res < -64'sd2147483648) res = -64'sd2147483648;
            end
            r.value = res[31:0];
         end
      end
      return r;
   endfunction

   function automatic int gap_cycles(int hi_prob);
      if (int'($urandom_range(0, 99)) >= hi_prob) return 0;
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 60))
                                         : int'($urandom_range(1, 3));
   endfunction

   // Holds valid through a zero gap so the next word follows without a second drive.
   task automatic send_word(bit op, logic signed [31:0] xv, logic signed [31:0] yv,
                            bit first);
      rsp_word_type wrd;
      int n;
      req_if.valid       <= 1;
      req_if.req_type    <= op;
      req_if.x_value     <= xv;
      req_if.y_value     <= yv;
      req_if.first_point <= first;
      do @(posedge clock); while (!req_if.ready);
      wrd = interpolate_word(op, xv, yv, first);
      expected_words = {expected_words, wrd};
      n = gap_cycles(40);
      if (n != 0) begin
         req_if.valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_if.valid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TolWidth-1:0] v);
      drain();
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      tol = v;
   endtask

   // Loads a non-decreasing table with random steps and values.
   task automatic load_table(int n, int max_step);
      logic signed [31:0] xv;
      xv = -$signed(32'($urandom_range(0, n * max_step / 2)));
      for (int i = 0; i < n; i++) begin
         send_word(0, xv, $urandom, i == 0);
         xv = xv + $urandom_range(0, max_step);
      end
   endtask

   task automatic test_directed();
      send_word(1, 0, 0, 0);                         // empty table
      send_word(0, 32'sh8000_0000, 32'sh7fff_ffff, 1);
      send_word(1, 0, 0, 0);                         // one point
      send_word(0, 32'sh7fff_ffff, 32'sh8000_0000, 0);
      send_word(1, 32'sh8000_0000, 0, 0);
      send_word(1, 32'sh7fff_ffff, 0, 0);
      send_word(1, 0, 32'shffff_ffff, 0);
      send_word(1, 32'sh4000_0000, 0, 0);
      send_word(0, 100, 5, 1);                       // zero-width segment
      send_word(0, 100, 9, 0);
      send_word(1, 100, 0, 0);
      send_word(1, 101, 0, 0);                       // out of range
      send_word(0, 50, 1, 0);                        // non-ascending
      send_word(1, 75, 0, 0);
      send_word(1, 60, 0, 0);
      for (int i = 0; i < Depth; i++) send_word(0, i * 1000, $urandom, i == 0);
      send_word(0, 1, 1, 0);                         // table full
      send_word(1, 62999, 0, 0);
      send_word(0, 7, 7, 1);                         // clear on a full table
   endtask

   task automatic test_tolerance(logic [TolWidth-1:0] v);
      write_tolerance(v);
      load_table($urandom_range(2, 8), 40000);
      send_word(1, -1, 0, 0);
      for (int i = 0; i < 20; i++)
         send_word(1, $signed(32'($urandom_range(0, 400000))) - 200000, 0, 0);
   endtask

   task automatic test_random(int n_items);
      int done;
      int n;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(0, 9))
            0: begin
               send_word($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 1));
               done++;
            end
            1: begin
               n = ($urandom_range(0, 9) == 0) ? Depth : int'($urandom_range(2, 10));
               load_table(n, $urandom_range(1, 200000));
               done += n;
            end
            default: begin
               if (npts >= 2) send_word(1, tab_x[0] + $signed(32'($urandom_range(0,
                     32'(longint'(tab_x[npts-1]) - tab_x[0] + 2)))) - 1, $urandom, 0);
               else send_word(1, $urandom, $urandom, 0);
               done++;
            end
         endcase
      end
   endtask

   // Response checker with random back-pressure.
   always @(posedge clock) begin
      rsp_word_type e;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("piecewise_linear_interpolator_unit: mismatch");
         $finish;
      end
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) report("unexpected word", 0, 0);
            else begin
               e = expected_words.pop_front();
               if (rsp_if.result_value !== e.value)
                  report("result_value", rsp_if.result_value, e.value);
               if (rsp_if.segment_index !== e.seg)
                  report("segment_index", rsp_if.segment_index, e.seg);
               if (rsp_if.status !== e.status) report("status", rsp_if.status, e.status);
            end
         end
         rsp_if.ready <= ($urandom_range(0, 9) < 7) || (cycles % 2000 < 500);
      end
   end

   initial begin
      req_if.valid = 0;
      req_if.req_type = 0;
      req_if.x_value = 0;
      req_if.y_value = 0;
      req_if.first_point = 0;
      rsp_if.ready = 0;
      for (int i = 0; i < Depth; i++) begin
         tab_x[i] = 0;
         tab_y[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_tolerance(16'hffff);
      test_tolerance(16'd0);
      test_tolerance(16'd50000);
      test_tolerance(16'($urandom));
      write_tolerance(16'($urandom_range(0, 3000)));
      test_random(1400);
      drain();
      if (errors == 0) $display("piecewise_linear_interpolator_unit: match");
      else $display("piecewise_linear_interpolator_unit: mismatch");
      $finish;
   end
endmodule
